// ===== hdl/tvdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvdmc_pkg
// Shared widths, codes, command/status bundles and saturation helper for the
// TVD MUSCL column advection block.
// ----------------------------------------------------------------------------
package tvdmc_pkg;

  localparam int W          = 32;                  // fixed point word
  localparam int FB         = 16;                  // fraction bits
  localparam int MAX_COLUMN = 4096;
  localparam int CELL_W     = $clog2(MAX_COLUMN);
  localparam int LIM_W      = 3;
  localparam int TS_W       = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_NW     = W + FB + 2;          // signed dividend / quotient
  localparam int DIV_DW     = W + 2;               // signed divisor
  localparam int MUL_W      = W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int HS_W       = W + 2;               // half slope
  localparam int PHI_W      = FB + 2;              // limiter output, up to 2.0
  localparam longint ONE    = longint'(1) << FB;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMITER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITIVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR      = 2'd3;

  localparam logic [LIM_W-1:0] LIM_MINMOD    = 3'd0;
  localparam logic [LIM_W-1:0] LIM_VANLEER   = 3'd1;
  localparam logic [LIM_W-1:0] LIM_SUPERBEE  = 3'd2;
  localparam logic [LIM_W-1:0] LIM_MC        = 3'd3;
  localparam logic [LIM_W-1:0] LIM_UNIVERSAL = 3'd4;

  localparam logic [1:0] DIV_RATIO = 2'd0;
  localparam logic [1:0] DIV_VANL  = 2'd1;
  localparam logic [1:0] DIV_TEND  = 2'd2;
  localparam logic [1:0] DIV_FLOOR = 2'd3;

  localparam logic MUL_SLOPE = 1'b0;
  localparam logic MUL_FLUX  = 1'b1;

  // which pending cell a result belongs to
  localparam logic [1:0] RES_A = 2'd0;   // cell two back
  localparam logic [1:0] RES_B = 2'd1;   // cell one back (flush)
  localparam logic [1:0] RES_C = 2'd2;   // last cell itself

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic       div_start;
    logic [1:0] div_src;
    logic       r_load;
    logic       phi_load;
    logic       mul_start;
    logic       mul_src;
    logic       hs_store;
    logic       flux_store;
    logic       tend_store;
    logic       floor_apply;
    logic       tend_zero;
    logic       out_load;
    logic       col_update;
    logic       hs_sel;
    logic [1:0] res_sel;
  } tvdmc_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       den_zero;
    logic       vl_need;
    logic       pos_en;
    logic       out_busy;
    logic [1:0] fill;
    logic       last;
  } tvdmc_stat_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(longint'(2147483647));
    lo = -hi - PROD_W'(longint'(1));
    if (x > hi)      return W'(hi);
    else if (x < lo) return W'(lo);
    else             return W'(x);
  endfunction

endpackage

// ===== hdl/tvdmc_if.sv =====
// ----------------------------------------------------------------------------
// tvdmc_if
// Item channels: cell input and tendency result, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tvdmc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tvdmc_pkg::W-1:0]    sample_value;
  logic signed [tvdmc_pkg::W-1:0]    cell_velocity;
  logic signed [tvdmc_pkg::W-1:0]    cell_spacing;
  logic                              column_end;
  modport source (output valid, sample_value, cell_velocity, cell_spacing, column_end,
                  input ready);
  modport sink   (input valid, sample_value, cell_velocity, cell_spacing, column_end,
                  output ready);
endinterface

interface tvdmc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tvdmc_pkg::W-1:0]    tendency;
  logic [tvdmc_pkg::CELL_W-1:0]      result_cell;
  logic                              column_done;
  modport source (output valid, tendency, result_cell, column_done, input ready);
  modport sink   (input valid, tendency, result_cell, column_done, output ready);
endinterface

// ===== hdl/tvdmc_div.sv =====
// ----------------------------------------------------------------------------
// tvdmc_div
// Shared signed divider, restoring, one quotient bit per cycle, truncating
// toward zero. done pulses for one cycle when quot is valid.
// ----------------------------------------------------------------------------
module tvdmc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tvdmc_pkg::DIV_NW-1:0] num,
  input  logic signed [tvdmc_pkg::DIV_DW-1:0] den,
  output logic                                done,
  output logic signed [tvdmc_pkg::DIV_NW-1:0] quot
);
  import tvdmc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dmag;
  logic [DIV_NW-1:0] qsh;
  logic              neg;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;

  assign rem_sh = {rem, qsh[DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, dmag};
  assign quot   = neg ? -signed'(qsh) : signed'(qsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of qsh as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      qsh  <= num[DIV_NW-1] ? DIV_NW'(-num) : DIV_NW'(num);
      dmag <= den[DIV_DW-1] ? DIV_DW'(-den) : DIV_DW'(den);
      neg  <= num[DIV_NW-1] ^ den[DIV_DW-1];
    end else if (busy) begin
      if (!diff[DIV_DW]) begin
        rem <= diff[DIV_DW-1:0];
        qsh <= {qsh[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_DW-1:0];
        qsh <= {qsh[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/tvdmc_datapath.sv =====
// ----------------------------------------------------------------------------
// tvdmc_datapath
// Cell windows, config registers, limiter, shared multiplier and divider,
// face fluxes, tendency and output register.
// ----------------------------------------------------------------------------
module tvdmc_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tvdmc_pkg::tvdmc_cmd_t                cmd,
  output tvdmc_pkg::tvdmc_stat_t               stat,
  input  logic                                 cfg_we,
  input  logic [tvdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tvdmc_pkg::W-1:0]              cfg_data,
  input  logic signed [tvdmc_pkg::W-1:0]       sample_value,
  input  logic signed [tvdmc_pkg::W-1:0]       cell_velocity,
  input  logic signed [tvdmc_pkg::W-1:0]       cell_spacing,
  input  logic                                 column_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tvdmc_pkg::W-1:0]       tendency,
  output logic [tvdmc_pkg::CELL_W-1:0]         result_cell,
  output logic                                 column_done
);
  import tvdmc_pkg::*;

  function automatic logic [PHI_W-1:0] lim_phi(input logic [LIM_W-1:0] mode,
                                               input logic signed [W-1:0] rv);
    logic signed [W+2:0] x;
    logic signed [W+2:0] two_x;
    logic signed [W+2:0] one;
    logic signed [W+2:0] two;
    logic signed [W+2:0] half;
    logic signed [W+2:0] a;
    logic signed [W+2:0] b;
    logic signed [W+2:0] res;
    x     = (W+3)'(rv);
    two_x = x <<< 1;
    one   = (W+3)'(ONE);
    two   = one <<< 1;
    half  = (one + x) >>> 1;
    res   = '0;
    unique case (mode)
      LIM_MINMOD: begin
        res = (one < x) ? one : x;
      end
      LIM_VANLEER: begin
        res = '0;                         // handled by the divider
      end
      LIM_SUPERBEE: begin
        a   = (one < two_x) ? one : two_x;
        b   = (two < x) ? two : x;
        res = (a > b) ? a : b;
      end
      LIM_UNIVERSAL: begin
        if (x < 0)         res = '0;
        else if (x <= one) res = (two_x < half) ? two_x : half;
        else               res = (x < two) ? x : two;
      end
      default: begin                      // MC, also unused codes
        a   = (half < two) ? half : two;
        res = (a < two_x) ? a : two_x;
      end
    endcase
    if (res < 0) res = '0;
    return res[PHI_W-1:0];
  endfunction

  // config
  logic [LIM_W-1:0]    lim_mode;
  logic                pos_en;
  logic [TS_W-1:0]     time_step;
  logic signed [W-1:0] floor_value;

  // column state
  logic signed [W-1:0] qw [4];      // q[k-3] .. q[k]
  logic signed [W-1:0] vw [3];
  logic signed [W-1:0] dw [3];
  logic [1:0]          fill;
  logic                last;
  logic [CELL_W-1:0]   cell_cnt;
  logic signed [W-1:0] prev_flux;

  // working registers
  logic signed [W-1:0]      r;
  logic [PHI_W-1:0]         phi;
  logic signed [HS_W-1:0]   hs [2];
  logic signed [PROD_W-1:0] prod;
  logic signed [W-1:0]      flux;
  logic signed [DIV_NW-1:0] tend;

  // slope operands
  logic signed [W-1:0]      qm, q0, qp;
  logic signed [W:0]        dl, dr;
  logic signed [DIV_DW-1:0] rden;
  logic signed [W-1:0]      r_special;

  // cell operands
  logic signed [W-1:0]      face_r, face_l, face, cv, cdx, cq;
  logic [W:0]               dxm;
  logic [TS_W-1:0]          dts;
  logic signed [W:0]        fdiff, qdiff;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     div_done;
  logic signed [DIV_NW-1:0] div_num, quot;
  logic signed [DIV_DW-1:0] div_den;

  always_comb begin
    if (cmd.hs_sel) begin
      qm = qw[1]; q0 = qw[2]; qp = qw[3];
    end else begin
      qm = qw[0]; q0 = qw[1]; qp = qw[2];
    end
    dl   = (W+1)'(q0) - (W+1)'(qm);
    dr   = (W+1)'(qp) - (W+1)'(q0);
    rden = DIV_DW'(dr) + DIV_DW'(1);
    if (dl > 0)      r_special = sat32(PROD_W'(longint'(2147483647)));
    else if (dl < 0) r_special = sat32(-PROD_W'(longint'(2147483648)));
    else             r_special = '0;
  end

  always_comb begin
    if (cmd.res_sel == RES_A) begin
      face_r = (fill == 2'd3) ? sat32(PROD_W'(HS_W'(qw[1]) + hs[0])) : qw[1];
      face_l = sat32(PROD_W'(HS_W'(qw[2]) - hs[1]));
      cv     = vw[0];
      cdx    = dw[0];
      cq     = qw[1];
    end else begin
      face_r = (fill >= 2'd2) ? sat32(PROD_W'(HS_W'(qw[2]) + hs[1])) : qw[2];
      face_l = qw[3];
      cv     = vw[1];
      cdx    = dw[1];
      cq     = (cmd.res_sel == RES_C) ? qw[3] : qw[2];
    end
    face  = (cv >= 0) ? face_r : face_l;
    dxm   = cdx[W-1] ? (W+1)'(-(W+1)'(cdx)) : (W+1)'(cdx);
    if (dxm == '0) dxm = (W+1)'(1);
    dts   = (time_step == '0) ? TS_W'(1) : time_step;
    fdiff = (W+1)'(flux) - (W+1)'(prev_flux);
    qdiff = (W+1)'(floor_value) - (W+1)'(cq);
  end

  always_comb begin
    if (cmd.mul_src == MUL_SLOPE) begin
      mul_a = MUL_W'(signed'({1'b0, phi}));
      mul_b = dr;
    end else begin
      mul_a = MUL_W'(cv);
      mul_b = MUL_W'(face);
    end
  end

  always_comb begin
    unique case (cmd.div_src)
      DIV_RATIO: begin
        div_num = DIV_NW'(dl) <<< FB;
        div_den = rden;
      end
      DIV_VANL: begin
        div_num = DIV_NW'(r) <<< (FB + 1);
        div_den = DIV_DW'(r) + DIV_DW'(ONE);
      end
      DIV_TEND: begin
        div_num = DIV_NW'(fdiff) <<< FB;
        div_den = DIV_DW'(dxm);
      end
      DIV_FLOOR: begin
        div_num = DIV_NW'(qdiff) <<< FB;
        div_den = DIV_DW'(dts);
      end
    endcase
  end

  tvdmc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    stat.div_done = div_done;
    stat.den_zero = (rden == '0);
    stat.vl_need  = (lim_mode == LIM_VANLEER) && (r > 0);
    stat.pos_en   = pos_en;
    stat.out_busy = out_valid;
    stat.fill     = fill;
    stat.last     = last;
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_mode    <= LIM_MC;
      pos_en      <= 1'b0;
      time_step   <= TS_W'(65536);
      floor_value <= '0;
      fill        <= '0;
      last        <= 1'b0;
      cell_cnt    <= '0;
      prev_flux   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIMITER:    lim_mode    <= cfg_data[LIM_W-1:0];
          CFG_POSITIVITY: pos_en      <= cfg_data[0];
          CFG_TIME_STEP:  time_step   <= cfg_data[TS_W-1:0];
          CFG_FLOOR:      floor_value <= signed'(cfg_data);
        endcase
      end
      if (cmd.load) last <= column_end;
      if (cmd.tend_store) prev_flux <= flux;
      if (cmd.col_update) begin
        if (last) begin
          fill      <= '0;
          cell_cnt  <= '0;
          prev_flux <= '0;
        end else begin
          fill     <= (fill == 2'd3) ? fill : fill + 2'd1;
          cell_cnt <= cell_cnt + CELL_W'(1);
        end
      end
      if (cmd.out_load)                 out_valid <= 1'b1;
      else if (out_valid && out_ready)  out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qw[0] <= qw[1];
      qw[1] <= qw[2];
      qw[2] <= qw[3];
      qw[3] <= sample_value;
      vw[0] <= vw[1];
      vw[1] <= vw[2];
      vw[2] <= cell_velocity;
      dw[0] <= dw[1];
      dw[1] <= dw[2];
      dw[2] <= cell_spacing;
    end
    if (cmd.r_load)
      r <= stat.den_zero ? r_special : sat32(PROD_W'(quot));
    if (cmd.phi_load)
      phi <= stat.vl_need ? quot[PHI_W-1:0] : lim_phi(lim_mode, r);
    if (cmd.mul_start) prod <= mul_a * mul_b;
    // floor of prod / 2^(FB+1) is an arithmetic shift
    if (cmd.hs_store) hs[cmd.hs_sel] <= prod[HS_W+FB:FB+1];
    if (cmd.flux_store) flux <= sat32(prod >>> FB);
    if (cmd.tend_store) tend <= -quot;
    else if (cmd.floor_apply && (quot > tend)) tend <= quot;
    else if (cmd.tend_zero) tend <= '0;
    if (cmd.out_load) begin
      tendency    <= sat32(PROD_W'(tend));
      column_done <= (cmd.res_sel == RES_C);
      unique case (cmd.res_sel)
        RES_A:   result_cell <= cell_cnt - CELL_W'(2);
        RES_B:   result_cell <= cell_cnt - CELL_W'(1);
        default: result_cell <= cell_cnt;
      endcase
    end
  end

endmodule

// ===== hdl/tvdmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvdmc_ctrl
// Sequencer: half slopes once enough cells are held, then each pending cell's
// flux, tendency, floor when enabled and emit, then column bookkeeping.
// ----------------------------------------------------------------------------
module tvdmc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  tvdmc_pkg::tvdmc_stat_t stat,
  output tvdmc_pkg::tvdmc_cmd_t  cmd
);
  import tvdmc_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_HS_BEGIN  = 4'd2;
  localparam logic [3:0] S_HS_RWAIT  = 4'd3;
  localparam logic [3:0] S_HS_PHI    = 4'd4;
  localparam logic [3:0] S_HS_VWAIT  = 4'd5;
  localparam logic [3:0] S_HS_MUL    = 4'd6;
  localparam logic [3:0] S_HS_STORE  = 4'd7;
  localparam logic [3:0] S_CELL_MUL  = 4'd8;
  localparam logic [3:0] S_CELL_FLUX = 4'd9;
  localparam logic [3:0] S_CELL_DIV  = 4'd10;
  localparam logic [3:0] S_CELL_WAIT = 4'd11;
  localparam logic [3:0] S_FIN       = 4'd12;
  localparam logic [3:0] S_FIN_WAIT  = 4'd13;
  localparam logic [3:0] S_EMIT      = 4'd14;
  localparam logic [3:0] S_ZERO      = 4'd15;

  logic [3:0] state, state_next;
  logic       sel, sel_next;
  logic [1:0] res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      res   <= RES_A;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      res   <= res_next;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.hs_sel  = sel;
    cmd.res_sel = res;
    state_next  = state;
    sel_next    = sel;
    res_next    = res;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.fill == 2'd3) begin
          sel_next   = 1'b0;
          state_next = S_HS_BEGIN;
        end else if (stat.fill == 2'd2) begin
          sel_next   = 1'b1;
          state_next = S_HS_BEGIN;
        end else if (stat.last && (stat.fill == 2'd1)) begin
          res_next   = RES_B;
          state_next = S_CELL_MUL;
        end else if (stat.last) begin
          state_next = S_ZERO;
        end else begin
          cmd.col_update = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_HS_BEGIN: begin
        cmd.div_src = DIV_RATIO;
        if (stat.den_zero) begin
          cmd.r_load = 1'b1;
          state_next = S_HS_PHI;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_HS_RWAIT;
        end
      end
      S_HS_RWAIT: begin
        cmd.div_src = DIV_RATIO;
        if (stat.div_done) begin
          cmd.r_load = 1'b1;
          state_next = S_HS_PHI;
        end
      end
      S_HS_PHI: begin
        cmd.div_src = DIV_VANL;
        if (stat.vl_need) begin
          cmd.div_start = 1'b1;
          state_next    = S_HS_VWAIT;
        end else begin
          cmd.phi_load = 1'b1;
          state_next   = S_HS_MUL;
        end
      end
      S_HS_VWAIT: begin
        if (stat.div_done) begin
          cmd.phi_load = 1'b1;
          state_next   = S_HS_MUL;
        end
      end
      S_HS_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = MUL_SLOPE;
        state_next    = S_HS_STORE;
      end
      S_HS_STORE: begin
        cmd.hs_store = 1'b1;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = S_HS_BEGIN;
        end else begin
          res_next   = RES_A;
          state_next = S_CELL_MUL;
        end
      end
      S_CELL_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = MUL_FLUX;
        state_next    = S_CELL_FLUX;
      end
      S_CELL_FLUX: begin
        cmd.flux_store = 1'b1;
        state_next     = S_CELL_DIV;
      end
      S_CELL_DIV: begin
        cmd.div_src   = DIV_TEND;
        cmd.div_start = 1'b1;
        state_next    = S_CELL_WAIT;
      end
      S_CELL_WAIT: begin
        if (stat.div_done) begin
          cmd.tend_store = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_FIN: begin
        cmd.div_src = DIV_FLOOR;
        if (stat.pos_en) begin
          cmd.div_start = 1'b1;
          state_next    = S_FIN_WAIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_FIN_WAIT: begin
        if (stat.div_done) begin
          cmd.floor_apply = 1'b1;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          if ((res == RES_A) && stat.last) begin
            res_next   = RES_B;
            state_next = S_CELL_MUL;
          end else if (res == RES_B) begin
            state_next = S_ZERO;
          end else begin
            cmd.col_update = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      S_ZERO: begin
        // last cell: zero tendency, floor only
        cmd.tend_zero = 1'b1;
        res_next      = RES_C;
        state_next    = S_FIN;
      end
    endcase
  end

endmodule

// ===== hdl/tvd_muscl_column_advection.sv =====
// ----------------------------------------------------------------------------
// tvd_muscl_column_advection
// Streaming MUSCL/TVD upwind advection tendency for one vertical column.
// ----------------------------------------------------------------------------
// One item at a time. Each division runs on the shared serial divider, and an
// item needs 0 to 9 of them: a mid-column cell needs more with van Leer and
// the floor on than with MC and the floor off, a column's last cell the most,
// and an item may also wait for the output register to empty.
// Results appear two cells late; the column's last cell flushes up to three.
// Synchronous active-high reset restores the default config, empties the
// column and drops the output item; no clearing pass.
module tvd_muscl_column_advection (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tvdmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvdmc_pkg::W-1:0]         cfg_data,
  tvdmc_in_if.sink                        in_ch,
  tvdmc_out_if.source                     out_ch
);
  import tvdmc_pkg::*;

  tvdmc_cmd_t  cmd;
  tvdmc_stat_t stat;

  assign in_ch.ready = cmd.in_ready;

  tvdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  tvdmc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_value  (in_ch.sample_value),
    .cell_velocity (in_ch.cell_velocity),
    .cell_spacing  (in_ch.cell_spacing),
    .column_end    (in_ch.column_end),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .tendency      (out_ch.tendency),
    .result_cell   (out_ch.result_cell),
    .column_done   (out_ch.column_done)
  );

endmodule

// ===== hdl/tvdmc_checker.sv =====
// ----------------------------------------------------------------------------
// tvdmc_checker
// Port-level checks on the advection block, bound to the top level.
// ----------------------------------------------------------------------------
module tvdmc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tvdmc_pkg::W-1:0]       tendency,
  input logic [tvdmc_pkg::CELL_W-1:0]  result_cell,
  input logic                          column_done
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output item present after reset");

  // one item in flight: the cycle after an accept the input side is closed
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is being worked on");

  // a taken result is never followed by another in the very next cycle
  a_out_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result reloaded in the cycle it was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(tendency) && $stable(result_cell) && $stable(column_done)))
    else $error("stalled result changed");

endmodule

bind tvd_muscl_column_advection tvdmc_checker u_tvdmc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tendency    (out_ch.tendency),
  .result_cell (out_ch.result_cell),
  .column_done (out_ch.column_done)
);
